// File: rtl/core/mdc_pkg.sv
// ----------------------------------------------------------------------------
// mdc_pkg
// Types and constants shared by the motion door controller core.
// ----------------------------------------------------------------------------
package mdc_pkg;

  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_DEBOUNCE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HOLD_OPEN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_BLINK_HALF = 2'd2;

  localparam logic [CFG_DATA_W-1:0] DEBOUNCE_RST   = 16'd50;
  localparam logic [CFG_DATA_W-1:0] HOLD_OPEN_RST  = 16'd10000;
  localparam logic [CFG_DATA_W-1:0] BLINK_HALF_RST = 16'd500;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] debounce_ticks;
    logic [CFG_DATA_W-1:0] hold_open_ticks;
    logic [CFG_DATA_W-1:0] blink_half_ticks;
  } cfg_t;

  typedef struct packed {
    logic motion_detected;
    logic door_open;
    logic indicator_on;
  } res_t;

endpackage

// File: rtl/core/mdc_if.sv
// ----------------------------------------------------------------------------
// mdc channel interfaces
// Valid/ready channels for sensor ticks, results and register writes.
// ----------------------------------------------------------------------------
interface mdc_in_if;
  logic valid;
  logic ready;
  logic sensor_pressed;

  modport source (output valid, output sensor_pressed, input ready);
  modport sink   (input valid, input sensor_pressed, output ready);
endinterface

interface mdc_out_if;
  logic valid;
  logic ready;
  logic motion_detected;
  logic door_open;
  logic indicator_on;

  modport source (output valid, output motion_detected, output door_open,
                  output indicator_on, input ready);
  modport sink   (input valid, input motion_detected, input door_open,
                  input indicator_on, output ready);
endinterface

interface mdc_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/mdc_cfg_regs.sv
// ----------------------------------------------------------------------------
// mdc_cfg_regs
// Configuration register file: debounce, hold-open and blink periods.
// ----------------------------------------------------------------------------
module mdc_cfg_regs
  import mdc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_idx,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_idx)
        CFG_IDX_DEBOUNCE:   cfg_nxt.debounce_ticks   = wr_data;
        CFG_IDX_HOLD_OPEN:  cfg_nxt.hold_open_ticks  = wr_data;
        CFG_IDX_BLINK_HALF: cfg_nxt.blink_half_ticks = wr_data;
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks   <= DEBOUNCE_RST;
      cfg_r.hold_open_ticks  <= HOLD_OPEN_RST;
      cfg_r.blink_half_ticks <= BLINK_HALF_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/core/mdc_ctrl.sv
// ----------------------------------------------------------------------------
// mdc_ctrl
// Per-tick update of the debounce, door and indicator machines.
// ----------------------------------------------------------------------------
module mdc_ctrl
  import mdc_pkg::*;
#(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic tick,
  input  logic sensor_pressed,
  input  cfg_t cfg,
  output res_t res_nxt
);

  typedef enum logic [1:0] {
    MOT_IDLE     = 2'd0,
    MOT_PEND_ON  = 2'd1,
    MOT_ACTIVE   = 2'd2,
    MOT_PEND_OFF = 2'd3
  } mot_t;

  typedef enum logic [1:0] {
    DOOR_CLOSED = 2'd0,
    DOOR_OPEN   = 2'd1,
    DOOR_WAIT   = 2'd2
  } door_t;

  typedef logic [TIMER_WIDTH-1:0] tmr_t;

  mot_t  mot_r,  mot_nxt;
  door_t door_r, door_nxt;
  logic  lamp_r, lamp_nxt;
  tmr_t  mot_cnt_r,  mot_cnt_nxt;
  tmr_t  door_cnt_r, door_cnt_nxt;
  tmr_t  lamp_cnt_r, lamp_cnt_nxt;

  tmr_t debounce_ld;
  tmr_t hold_ld;
  tmr_t blink_ld;
  logic motion;

  assign debounce_ld = tmr_t'(cfg.debounce_ticks);
  assign hold_ld     = tmr_t'(cfg.hold_open_ticks);
  assign blink_ld    = tmr_t'(cfg.blink_half_ticks);

  always_comb begin
    // countdowns step toward zero first
    mot_cnt_nxt  = (mot_cnt_r  != '0) ? mot_cnt_r  - tmr_t'(1) : '0;
    door_cnt_nxt = (door_cnt_r != '0) ? door_cnt_r - tmr_t'(1) : '0;
    lamp_cnt_nxt = (lamp_cnt_r != '0) ? lamp_cnt_r - tmr_t'(1) : '0;

    // debounce
    mot_nxt = mot_r;
    case (mot_r)
      MOT_IDLE: begin
        if (sensor_pressed) begin
          mot_nxt     = MOT_PEND_ON;
          mot_cnt_nxt = debounce_ld;
        end
      end
      MOT_PEND_ON: begin
        if (!sensor_pressed) mot_nxt = MOT_IDLE;
        else if (mot_cnt_nxt == '0) mot_nxt = MOT_ACTIVE;
      end
      MOT_ACTIVE: begin
        if (sensor_pressed) begin
          mot_nxt     = MOT_PEND_OFF;
          mot_cnt_nxt = debounce_ld;
        end
      end
      default: begin
        if (!sensor_pressed) mot_nxt = MOT_ACTIVE;
        else if (mot_cnt_nxt == '0) mot_nxt = MOT_IDLE;
      end
    endcase
    motion = mot_nxt[1];

    // door, open falls through to the waiting check in the same tick
    door_nxt = door_r;
    if (door_r == DOOR_OPEN && !motion) begin
      door_nxt     = DOOR_WAIT;
      door_cnt_nxt = hold_ld;
    end
    case (door_nxt)
      DOOR_OPEN, DOOR_WAIT: begin
        if (motion) door_nxt = DOOR_OPEN;
        else if (door_cnt_nxt == '0) door_nxt = DOOR_CLOSED;
      end
      default: begin
        door_nxt = motion ? DOOR_OPEN : DOOR_CLOSED;
      end
    endcase

    // indicator
    lamp_nxt = lamp_r;
    if (!lamp_r) begin
      if (motion && lamp_cnt_nxt == '0) begin
        lamp_nxt     = 1'b1;
        lamp_cnt_nxt = blink_ld;
      end
    end else if (lamp_cnt_nxt == '0) begin
      lamp_nxt     = 1'b0;
      lamp_cnt_nxt = blink_ld;
    end

    res_nxt.motion_detected = motion;
    res_nxt.door_open       = (door_nxt != DOOR_CLOSED);
    res_nxt.indicator_on    = lamp_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mot_r      <= MOT_IDLE;
      door_r     <= DOOR_CLOSED;
      lamp_r     <= 1'b0;
      mot_cnt_r  <= '0;
      door_cnt_r <= '0;
      lamp_cnt_r <= '0;
    end else if (tick) begin
      mot_r      <= mot_nxt;
      door_r     <= door_nxt;
      lamp_r     <= lamp_nxt;
      mot_cnt_r  <= mot_cnt_nxt;
      door_cnt_r <= door_cnt_nxt;
      lamp_cnt_r <= lamp_cnt_nxt;
    end
  end

endmodule

// File: rtl/core/motion_door_controller_core.sv
// A result passes the input register and then the result register before it is offered.
// Throughput: one tick per cycle unless the status channel back-pressures; the
//   next-state logic between the input register and the result register is combinational.
// Reset: rst_n synchronous active low; machines closed/idle, countdowns zero,
//   periods back to 50, 10000 and 500 ticks.
// ----------------------------------------------------------------------------
// motion_door_controller_core
// Debounced motion sensing, door hold-open timing and blinking indicator.
// ----------------------------------------------------------------------------
module motion_door_controller_core
  import mdc_pkg::*;
#(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  mdc_in_if.sink           in_ch,
  mdc_out_if.source        out_ch,
  mdc_cfg_if.sink          cfg_ch
);

  logic in_vld_r;
  logic in_sensor_r;
  logic out_vld_r;
  res_t out_res_r;
  res_t res_nxt;
  cfg_t cfg;
  logic advance;

  // input stage moves on when the result register is free or being drained
  assign advance     = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || advance;
  assign cfg_ch.ready = 1'b1;

  mdc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_ch.valid),
    .wr_idx  (cfg_ch.index),
    .wr_data (cfg_ch.data),
    .cfg     (cfg)
  );

  mdc_ctrl #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .tick           (advance),
    .sensor_pressed (in_sensor_r),
    .cfg            (cfg),
    .res_nxt        (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ch.ready) in_vld_r <= in_ch.valid;
      if (advance) out_vld_r <= 1'b1;
      else if (out_ch.ready) out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) in_sensor_r <= in_ch.sensor_pressed;
    if (advance) out_res_r <= res_nxt;
  end

  assign out_ch.valid           = out_vld_r;
  assign out_ch.motion_detected = out_res_r.motion_detected;
  assign out_ch.door_open       = out_res_r.door_open;
  assign out_ch.indicator_on    = out_res_r.indicator_on;

endmodule

// File: sim/mdc_status_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdc_status_checker
// Watches the tick, status and period channels of the door controller,
// predicts the debounced motion, door and lamp status for every tick transfer
// and compares each status transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module mdc_status_checker
  import mdc_pkg::*;
#(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  logic clk,
  input  logic rst_n,
  mdc_in_if    in_mon,
  mdc_out_if   out_mon,
  mdc_cfg_if   cfg_mon,
  output int   fail_count,
  output int   results_seen
);

  typedef enum logic [1:0] {
    MOTION_NONE, MOTION_ARMING, MOTION_ON, MOTION_DISARMING
  } motion_phase_e;

  typedef enum logic [1:0] {
    DOOR_CLOSED, DOOR_OPEN, DOOR_CLOSING, DOOR_SPARE
  } door_phase_e;

  typedef enum logic {LAMP_OFF, LAMP_ON} lamp_phase_e;

  cfg_t                   periods;
  motion_phase_e          motion_q;
  door_phase_e            door_q;
  lamp_phase_e            lamp_q;
  logic [TIMER_WIDTH-1:0] motion_cnt;
  logic [TIMER_WIDTH-1:0] door_cnt;
  logic [TIMER_WIDTH-1:0] lamp_cnt;
  res_t                   expected_status[$];
  int                     mismatch_count = 0;
  int                     status_count = 0;

  assign fail_count   = mismatch_count;
  assign results_seen = status_count;

  function automatic logic [TIMER_WIDTH-1:0] count_toward_zero(
    input logic [TIMER_WIDTH-1:0] cnt
  );
    return (cnt != '0) ? cnt - 1'b1 : '0;
  endfunction

  function automatic res_t tick_controller(input logic pressed);
    logic motion;
    res_t status;
    motion_cnt = count_toward_zero(motion_cnt);
    door_cnt   = count_toward_zero(door_cnt);
    lamp_cnt   = count_toward_zero(lamp_cnt);

    case (motion_q)
      MOTION_NONE: begin
        if (pressed) begin
          motion_q   = MOTION_ARMING;
          motion_cnt = TIMER_WIDTH'(periods.debounce_ticks);
        end
      end
      MOTION_ARMING: begin
        if (!pressed) motion_q = MOTION_NONE;
        else if (motion_cnt == '0) motion_q = MOTION_ON;
      end
      MOTION_ON: begin
        if (pressed) begin
          motion_q   = MOTION_DISARMING;
          motion_cnt = TIMER_WIDTH'(periods.debounce_ticks);
        end
      end
      default: begin
        if (!pressed) motion_q = MOTION_ON;
        else if (motion_cnt == '0) motion_q = MOTION_NONE;
      end
    endcase
    motion = (motion_q == MOTION_ON) || (motion_q == MOTION_DISARMING);

    // losing motion starts the hold-open wait and checks it in the same tick
    if (door_q == DOOR_OPEN && !motion) begin
      door_q   = DOOR_CLOSING;
      door_cnt = TIMER_WIDTH'(periods.hold_open_ticks);
    end
    if (door_q == DOOR_OPEN || door_q == DOOR_CLOSING) begin
      if (motion) door_q = DOOR_OPEN;
      else if (door_cnt == '0) door_q = DOOR_CLOSED;
    end else begin
      door_q = motion ? DOOR_OPEN : DOOR_CLOSED;
    end

    // an on phase always runs out and is followed by a full off phase
    if (lamp_q == LAMP_OFF) begin
      if (motion && lamp_cnt == '0) begin
        lamp_q   = LAMP_ON;
        lamp_cnt = TIMER_WIDTH'(periods.blink_half_ticks);
      end
    end else if (lamp_cnt == '0) begin
      lamp_q   = LAMP_OFF;
      lamp_cnt = TIMER_WIDTH'(periods.blink_half_ticks);
    end

    status.motion_detected = motion;
    status.door_open       = (door_q != DOOR_CLOSED);
    status.indicator_on    = (lamp_q == LAMP_ON);
    return status;
  endfunction

  function automatic int field_wrong(input string name, input logic want, input logic got);
    if (got === want) return 0;
    $display("%0t: %s mismatch, expected %b, actual %b", $time, name, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin
    int   bad;
    res_t want;
    bad = 0;
    if (!rst_n) begin
      periods    = '{DEBOUNCE_RST, HOLD_OPEN_RST, BLINK_HALF_RST};
      motion_q   = MOTION_NONE;
      door_q     = DOOR_CLOSED;
      lamp_q     = LAMP_OFF;
      motion_cnt = '0;
      door_cnt   = '0;
      lamp_cnt   = '0;
      expected_status.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_IDX_DEBOUNCE:   periods.debounce_ticks   = cfg_mon.data;
          CFG_IDX_HOLD_OPEN:  periods.hold_open_ticks  = cfg_mon.data;
          CFG_IDX_BLINK_HALF: periods.blink_half_ticks = cfg_mon.data;
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        status_count <= status_count + 1;
        if (expected_status.size() == 0) begin
          $display("%0t: status transfer with nothing expected, expected none, actual %b%b%b",
                   $time, out_mon.motion_detected, out_mon.door_open, out_mon.indicator_on);
          bad = 1;
        end else begin
          want = expected_status.pop_front();
          bad = field_wrong("motion_detected", want.motion_detected, out_mon.motion_detected)
              + field_wrong("door_open", want.door_open, out_mon.door_open)
              + field_wrong("indicator_on", want.indicator_on, out_mon.indicator_on);
        end
      end
      if (in_mon.valid && in_mon.ready)
        expected_status.push_back(tick_controller(in_mon.sensor_pressed));
    end
    if (bad != 0) mismatch_count <= mismatch_count + bad;
  end

endmodule

// File: sim/tb_motion_door_controller_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_motion_door_controller_core
// Drives sensor ticks and period writes into the door controller with random
// gaps and status back-pressure; a checker beside the core predicts and
// compares every status transfer, and this module reports the verdict.
// ----------------------------------------------------------------------------
module tb_motion_door_controller_core;
  import mdc_pkg::*;

  localparam int unsigned          TIMER_WIDTH   = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
  localparam int                   IDLE_LIMIT    = 4000;
  localparam int                   RANDOM_PHASES = 13;
  localparam int                   PHASE_TICKS   = 110;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  bit   steady = 1'b0;
  int   ticks_sent = 0;
  int   stall_left = 0;
  int   idle_cycles = 0;
  int   fail_count;
  int   results_seen;
  cfg_t periods = '{DEBOUNCE_RST, HOLD_OPEN_RST, BLINK_HALF_RST};

  mdc_in_if  in_ch();
  mdc_out_if out_ch();
  mdc_cfg_if cfg_ch();

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  motion_door_controller_core #(.TIMER_WIDTH(TIMER_WIDTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  mdc_status_checker #(.TIMER_WIDTH(TIMER_WIDTH)) checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .cfg_mon      (cfg_ch),
    .fail_count   (fail_count),
    .results_seen (results_seen)
  );

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // status back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left != 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (!steady && $urandom_range(0, 99) < 20) begin
      out_ch.ready <= 1'b0;
      stall_left   <= idle_len();
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_tick(input logic pressed);
    int gap;
    in_ch.valid          <= 1'b1;
    in_ch.sensor_pressed <= pressed;
    do @(posedge clk); while (!in_ch.ready);
    ticks_sent++;
    gap = steady ? 0 : idle_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_pattern(input logic [15:0] bits, input int n);
    for (int i = n - 1; i >= 0; i--) send_tick(bits[i]);
  endtask

  task automatic wait_drained();
    while (results_seen != ticks_sent) @(posedge clk);
  endtask

  // cfg valid is left high between back-to-back writes
  task automatic write_period(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_IDX_DEBOUNCE:   periods.debounce_ticks   = data;
      CFG_IDX_HOLD_OPEN:  periods.hold_open_ticks  = data;
      CFG_IDX_BLINK_HALF: periods.blink_half_ticks = data;
      default: ;
    endcase
  endtask

  task automatic load_periods(input logic [15:0] deb, input logic [15:0] hold,
                              input logic [15:0] blink, input bit with_spare);
    in_ch.valid <= 1'b0;
    wait_drained();
    if (with_spare) write_period(CFG_IDX_SPARE, 16'($urandom_range(0, 65535)));
    write_period(CFG_IDX_DEBOUNCE, deb);
    write_period(CFG_IDX_HOLD_OPEN, hold);
    write_period(CFG_IDX_BLINK_HALF, blink);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [15:0] pick_period(input int short_max, input int mid_max);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 16'($urandom_range(0, short_max));
    if (r < 85) return 16'($urandom_range(short_max + 1, mid_max));
    return 16'($urandom_range(0, 65535));
  endfunction

  // mostly press and release runs long enough to toggle motion or close the door
  task automatic drive_motion_pattern(input int n_ticks);
    int   left;
    int   run;
    int   deb;
    int   hold;
    logic level;
    left  = n_ticks;
    level = 1'b0;
    deb   = (periods.debounce_ticks > 40) ? 40 : int'(periods.debounce_ticks);
    hold  = (periods.hold_open_ticks > 40) ? 40 : int'(periods.hold_open_ticks);
    while (left > 0) begin
      if ($urandom_range(0, 9) < 7) begin
        level = ~level;
        if (!level) run = $urandom_range(1, hold + 4);
        else if ($urandom_range(0, 3) == 0) run = $urandom_range(1, deb + 1);
        else run = deb + 2 + $urandom_range(0, 3);
        repeat (run) if (left > 0) begin
          send_tick(level);
          left--;
        end
      end else begin
        run = $urandom_range(1, 8);
        repeat (run) if (left > 0) begin
          send_tick(1'($urandom_range(0, 1)));
          left--;
        end
      end
    end
  endtask

  initial begin
    in_ch.valid          = 1'b0;
    in_ch.sensor_pressed = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = CFG_IDX_DEBOUNCE;
    cfg_ch.data          = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset periods: short press that never reaches the debounce period
    send_pattern(16'b1100, 4);
    // zero periods, plus a write to the unused index
    load_periods(16'd0, 16'd0, 16'd0, 1'b1);
    send_pattern(16'b1100110010, 10);
    // maximum periods
    load_periods(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    send_pattern(16'b111010, 6);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      load_periods(pick_period(6, 30), pick_period(25, 60), pick_period(8, 30),
                   $urandom_range(0, 3) == 0);
      steady = (ph % 4 == 3);
      drive_motion_pattern(PHASE_TICKS);
    end
    steady = 1'b0;

    in_ch.valid <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
